// File: src/bitmap_page_allocator_top_defines.svh
// Assertion macros used by bitmap_page_allocator_top
`ifndef BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH
`define BITMAP_PAGE_ALLOCATOR_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// Check that cons holds in the same cycle as ante
`define BPA_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("bpa: same-cycle check failed");

// Check that cons holds in the cycle after ante
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("bpa: next-cycle check failed");

`else

`define BPA_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define BPA_ASSERT_NEXT(label, clk, rst_n, ante, cons)

`endif

`endif

// File: src/bpa_pkg.sv
package bpa_pkg;

    // Default number of physical pages
    localparam int NUM_PAGES_DEF = 4096;

    // Field widths
    localparam int IDX_W  = 12;
    localparam int CNT_W  = 13;
    localparam int PAGE_W = 13;

    // Bitmap word organization
    localparam int WORD_W = 32;
    localparam int WSH    = 5;
    localparam int WIDX_W = PAGE_W - WSH;

    // Page total after reset
    localparam logic [CNT_W-1:0] RANGE_RESET = 13'd4096;

    // Request codes
    localparam logic REQ_ALLOC = 1'b0;
    localparam logic REQ_FREE  = 1'b1;

endpackage

// File: src/bpa_req_if.sv
interface bpa_req_if
    import bpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             req_type;
    logic [IDX_W-1:0] page_index;
    logic [CNT_W-1:0] count;

    modport source (output valid, output req_type, output page_index, output count,
                    input ready);
    modport sink   (input valid, input req_type, input page_index, input count,
                    output ready);
endinterface

// File: src/bpa_res_if.sv
interface bpa_res_if
    import bpa_pkg::*;
();
    logic             valid;
    logic             ready;
    logic             ok;
    logic [IDX_W-1:0] first_page;
    logic [CNT_W-1:0] free_count;

    modport source (output valid, output ok, output first_page, output free_count,
                    input ready);
    modport sink   (input valid, input ok, input first_page, input free_count,
                    output ready);
endinterface

// File: src/bpa_ram.sv
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                                   i_clk,
    input  logic                                   i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                       i_wdata,
    input  logic                                   i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                       o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write one word, read one word with registered data
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end
endmodule

// File: src/bitmap_page_allocator_top.sv
// Allocate: a scan reads bitmap words from word 0 up to the hit (at most ceil(limit/32)),
// then a read-modify-write pass marks the words the run spans; a failed check skips both.
// Free: a read-modify-write pass over the words the range covers. One request in
// flight; the rate is set by the single bitmap read port, one 32-page word per cycle.
// Reset is synchronous, active low; afterwards a sweep over all ceil(NUM_PAGES/32) words
// marks every page used while the request port stays not ready.
`include "bitmap_page_allocator_top_defines.svh"

module bitmap_page_allocator_top
    import bpa_pkg::*;
#(
    parameter int NUM_PAGES = NUM_PAGES_DEF
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    bpa_req_if.sink          i_req,
    bpa_res_if.source        o_res,
    input  logic             i_cfg_wr_en,
    input  logic [CNT_W-1:0] i_cfg_wr_data
);
    localparam int DEPTH = (NUM_PAGES + WORD_W - 1) / WORD_W;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [AW-1:0] LAST_ADDR = AW'(DEPTH - 1);
    localparam logic [CNT_W-1:0] LIMIT_RESET =
        (32'(NUM_PAGES) < 32'(RANGE_RESET)) ? CNT_W'(NUM_PAGES) : RANGE_RESET;

    typedef enum logic [2:0] {
        S_INIT, S_IDLE, S_SCAN, S_MARK, S_FREE, S_DONE
    } t_state;

    t_state              r_state, n_state;
    logic [AW-1:0]       r_init, n_init;
    logic [CNT_W-1:0]    r_limit, n_limit;
    logic [CNT_W-1:0]    r_free_total, n_free_total;
    logic [CNT_W-1:0]    r_count, n_count;
    logic [CNT_W-1:0]    r_run, n_run;
    logic [PAGE_W-1:0]   r_start, n_start;
    logic [PAGE_W-1:0]   r_end, n_end;
    logic [WIDX_W-1:0]   r_rd_word, n_rd_word;
    logic [WIDX_W-1:0]   r_last_word, n_last_word;
    logic                r_res_ok, n_res_ok;
    logic [IDX_W-1:0]    r_res_first, n_res_first;
    logic                r_ovalid, n_ovalid;
    logic                r_o_ok, n_o_ok;
    logic [IDX_W-1:0]    r_o_first, n_o_first;
    logic [CNT_W-1:0]    r_o_free, n_o_free;

    logic                ram_we;
    logic [AW-1:0]       ram_waddr;
    logic [WORD_W-1:0]   ram_wdata;
    logic                ram_re;
    logic [AW-1:0]       ram_raddr;
    logic [WORD_W-1:0]   ram_rdata;

    logic [WORD_W-1:0]   s_lmask;
    logic [WORD_W-1:0]   s_free;
    logic [CNT_W-1:0]    s_run [WORD_W];
    logic [WORD_W-1:0]   s_hit;
    logic                s_any;
    logic [WSH-1:0]      s_pos;
    logic [PAGE_W-1:0]   s_hit_end;
    logic [PAGE_W-1:0]   s_hit_start;

    logic [WSH-1:0]      m_lo, m_hi;
    logic [WORD_W-1:0]   m_mask;
    logic [WORD_W-1:0]   m_cleared;
    logic [1:0]          pc1 [16];
    logic [2:0]          pc2 [8];
    logic [3:0]          pc3 [4];
    logic [4:0]          pc4 [2];
    logic [5:0]          pc5;

    logic [CNT_W-1:0]    lim_m1;
    logic [PAGE_W-1:0]   f_start;
    logic [PAGE_W:0]     f_end;

    // Bitmap storage, one word of 32 used bits per entry
    bpa_ram #(
        .WIDTH(WORD_W),
        .DEPTH(DEPTH)
    ) u_bitmap (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_waddr),
        .i_wdata(ram_wdata),
        .i_re   (ram_re),
        .i_raddr(ram_raddr),
        .o_rdata(ram_rdata)
    );

    assign i_req.ready      = (r_state == S_IDLE);
    assign o_res.valid      = r_ovalid;
    assign o_res.ok         = r_o_ok;
    assign o_res.first_page = r_o_first;
    assign o_res.free_count = r_o_free;

    assign lim_m1 = r_limit - CNT_W'(1);

    // Find the lowest page in this word where a free run reaches the count
    always_comb begin
        logic           seen;
        logic [WSH-1:0] lastu;
        s_lmask = (r_rd_word == r_limit[CNT_W-1:WSH])
                ? ((WORD_W'(1) << r_limit[WSH-1:0]) - WORD_W'(1))
                : {WORD_W{1'b1}};
        s_free  = ~ram_rdata & s_lmask;
        for (int j = 0; j < WORD_W; j++) begin
            seen  = 1'b0;
            lastu = '0;
            for (int k = 0; k < WORD_W; k++) begin
                if (k <= j && !s_free[k]) begin
                    seen  = 1'b1;
                    lastu = WSH'(k);
                end
            end
            s_run[j] = seen ? CNT_W'(WSH'(j) - lastu) : (r_run + CNT_W'(j) + CNT_W'(1));
            s_hit[j] = s_free[j] && (s_run[j] >= r_count);
        end
        s_any = |s_hit;
        s_pos = '0;
        for (int j = WORD_W - 1; j >= 0; j--) begin
            if (s_hit[j]) begin
                s_pos = WSH'(j);
            end
        end
        s_hit_end   = {r_rd_word, s_pos};
        s_hit_start = s_hit_end + PAGE_W'(1) - r_count;
    end

    // Build the page mask of the current word and count the pages it frees
    always_comb begin
        m_lo   = (r_rd_word == r_start[PAGE_W-1:WSH]) ? r_start[WSH-1:0] : '0;
        m_hi   = (r_rd_word == r_end[PAGE_W-1:WSH]) ? r_end[WSH-1:0] : '1;
        m_mask = ({WORD_W{1'b1}} << m_lo) & ({WORD_W{1'b1}} >> (WSH'(WORD_W - 1) - m_hi));
        m_cleared = ram_rdata & m_mask;
        for (int i = 0; i < 16; i++) begin
            pc1[i] = {1'b0, m_cleared[2*i]} + {1'b0, m_cleared[2*i+1]};
        end
        for (int i = 0; i < 8; i++) begin
            pc2[i] = {1'b0, pc1[2*i]} + {1'b0, pc1[2*i+1]};
        end
        for (int i = 0; i < 4; i++) begin
            pc3[i] = {1'b0, pc2[2*i]} + {1'b0, pc2[2*i+1]};
        end
        for (int i = 0; i < 2; i++) begin
            pc4[i] = {1'b0, pc3[2*i]} + {1'b0, pc3[2*i+1]};
        end
        pc5 = {1'b0, pc4[0]} + {1'b0, pc4[1]};
    end

    // Sequence the init sweep that marks every page used, the scan and the read-modify-write passes
    always_comb begin
        n_state      = r_state;
        n_init       = r_init;
        n_limit      = r_limit;
        n_free_total = r_free_total;
        n_count      = r_count;
        n_run        = r_run;
        n_start      = r_start;
        n_end        = r_end;
        n_rd_word    = r_rd_word;
        n_last_word  = r_last_word;
        n_res_ok     = r_res_ok;
        n_res_first  = r_res_first;
        n_ovalid     = r_ovalid && !o_res.ready;
        n_o_ok       = r_o_ok;
        n_o_first    = r_o_first;
        n_o_free     = r_o_free;
        ram_we       = 1'b0;
        ram_waddr    = AW'(r_rd_word);
        ram_wdata    = ram_rdata | m_mask;
        ram_re       = 1'b0;
        f_start      = PAGE_W'(i_req.page_index);
        f_end        = {1'b0, f_start} + (PAGE_W+1)'(i_req.count) - (PAGE_W+1)'(1);

        // Take a register write, clipped to the bitmap size
        if (i_cfg_wr_en) begin
            n_limit = (32'(i_cfg_wr_data) > 32'(NUM_PAGES)) ? CNT_W'(NUM_PAGES)
                                                             : i_cfg_wr_data;
        end

        case (r_state)
            S_INIT: begin
                ram_we    = 1'b1;
                ram_waddr = r_init;
                ram_wdata = {WORD_W{1'b1}};
                n_init    = r_init + AW'(1);
                if (r_init == LAST_ADDR) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_req.valid) begin
                    if (i_req.req_type == REQ_ALLOC) begin
                        if (i_req.count == '0 || i_req.count > r_free_total ||
                            i_req.count > r_limit) begin
                            n_res_ok    = 1'b0;
                            n_res_first = '0;
                            n_state     = S_DONE;
                        end else begin
                            n_count     = i_req.count;
                            n_run       = '0;
                            n_last_word = lim_m1[CNT_W-1:WSH];
                            n_rd_word   = '0;
                            ram_re      = 1'b1;
                            n_state     = S_SCAN;
                        end
                    end else begin
                        if (i_req.count == '0 || f_start >= r_limit) begin
                            n_res_ok    = 1'b1;
                            n_res_first = '0;
                            n_state     = S_DONE;
                        end else begin
                            n_start   = f_start;
                            n_end     = (f_end >= (PAGE_W+1)'(r_limit)) ? lim_m1
                                                                        : f_end[PAGE_W-1:0];
                            n_rd_word = f_start[PAGE_W-1:WSH];
                            ram_re    = 1'b1;
                            n_state   = S_FREE;
                        end
                    end
                end
            end
            S_SCAN: begin
                if (s_any) begin
                    n_end     = s_hit_end;
                    n_start   = s_hit_start;
                    n_rd_word = s_hit_start[PAGE_W-1:WSH];
                    ram_re    = 1'b1;
                    n_state   = S_MARK;
                end else if (r_rd_word == r_last_word) begin
                    n_res_ok    = 1'b0;
                    n_res_first = '0;
                    n_state     = S_DONE;
                end else begin
                    n_run     = s_run[WORD_W-1];
                    n_rd_word = r_rd_word + WIDX_W'(1);
                    ram_re    = 1'b1;
                end
            end
            S_MARK: begin
                ram_we    = 1'b1;
                ram_wdata = ram_rdata | m_mask;
                if (r_rd_word == r_end[PAGE_W-1:WSH]) begin
                    n_res_ok     = 1'b1;
                    n_res_first  = r_start[IDX_W-1:0];
                    n_free_total = r_free_total - r_count;
                    n_state      = S_DONE;
                end else begin
                    n_rd_word = r_rd_word + WIDX_W'(1);
                    ram_re    = 1'b1;
                end
            end
            S_FREE: begin
                ram_we       = 1'b1;
                ram_wdata    = ram_rdata & ~m_mask;
                n_free_total = r_free_total + CNT_W'(pc5);
                if (r_rd_word == r_end[PAGE_W-1:WSH]) begin
                    n_res_ok    = 1'b1;
                    n_res_first = '0;
                    n_state     = S_DONE;
                end else begin
                    n_rd_word = r_rd_word + WIDX_W'(1);
                    ram_re    = 1'b1;
                end
            end
            S_DONE: begin
                // Hold the result until the output register frees up
                if (!r_ovalid || o_res.ready) begin
                    n_ovalid  = 1'b1;
                    n_o_ok    = r_res_ok;
                    n_o_first = r_res_first;
                    n_o_free  = r_free_total;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        ram_raddr = AW'(n_rd_word);
    end

    // Hold state, counters and the output beat
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_INIT;
            r_init       <= '0;
            r_limit      <= LIMIT_RESET;
            r_free_total <= '0;
            r_ovalid     <= 1'b0;
        end else begin
            r_state      <= n_state;
            r_init       <= n_init;
            r_limit      <= n_limit;
            r_free_total <= n_free_total;
            r_ovalid     <= n_ovalid;
        end
        r_count     <= n_count;
        r_run       <= n_run;
        r_start     <= n_start;
        r_end       <= n_end;
        r_rd_word   <= n_rd_word;
        r_last_word <= n_last_word;
        r_res_ok    <= n_res_ok;
        r_res_first <= n_res_first;
        r_o_ok      <= n_o_ok;
        r_o_first   <= n_o_first;
        r_o_free    <= n_o_free;
    end

    // Read and write never hit the same bitmap word in one cycle
    `BPA_ASSERT_SAME(a_no_rw_clash, i_clk, i_rst_n, ram_we && ram_re, ram_waddr != ram_raddr)
    // A carried run is always shorter than the requested count
    `BPA_ASSERT_SAME(a_run_below_count, i_clk, i_rst_n, r_state == S_SCAN, r_run < r_count)
    // Free pages never exceed the largest page total
    `BPA_ASSERT_SAME(a_free_bound, i_clk, i_rst_n, 1'b1, r_free_total <= RANGE_RESET)
    // A failed allocation reports page zero
    `BPA_ASSERT_SAME(a_fail_page, i_clk, i_rst_n, r_ovalid && !r_o_ok, r_o_first == '0)
    // An accepted beat leaves the idle state
    `BPA_ASSERT_NEXT(a_accept_busy, i_clk, i_rst_n, i_req.valid && i_req.ready,
                     r_state != S_IDLE)

endmodule

// File: test/bitmap_page_allocator_top_tb.sv
`timescale 1ns / 100ps

module bitmap_page_allocator_top_tb
    import bpa_pkg::*;
();

    localparam int unsigned LIMIT_CYCLES = 2000000;
    localparam int unsigned N_SEG        = 6;
    localparam int unsigned N_DIR        = 20;
    localparam int unsigned RES_HOLD     = 600;

    typedef struct packed {
        logic             req_type;
        logic [IDX_W-1:0] page_index;
        logic [CNT_W-1:0] count;
    } t_page_req;

    typedef struct packed {
        logic             ok;
        logic [IDX_W-1:0] first_page;
        logic [CNT_W-1:0] free_count;
    } t_page_res;

    typedef struct packed {
        t_page_req rq;
        logic      has_want;
        t_page_res want;
    } t_dir_row;

    typedef struct {
        int unsigned start;
        int unsigned len;
    } t_page_run;

    // Directed beats; a fixed result is typed in only where it is obvious
    localparam t_dir_row DIR_TAB [0:N_DIR-1] = '{
        '{'{REQ_ALLOC, 12'd0,    13'd1},    1'b1, '{1'b0, 12'd0,    13'd0}},
        '{'{REQ_ALLOC, 12'd4095, 13'd0},    1'b1, '{1'b0, 12'd0,    13'd0}},
        '{'{REQ_FREE,  12'd0,    13'd0},    1'b1, '{1'b1, 12'd0,    13'd0}},
        '{'{REQ_FREE,  12'd4095, 13'd4096}, 1'b1, '{1'b1, 12'd0,    13'd1}},
        '{'{REQ_ALLOC, 12'd0,    13'd2},    1'b1, '{1'b0, 12'd0,    13'd1}},
        '{'{REQ_ALLOC, 12'd0,    13'd1},    1'b1, '{1'b1, 12'd4095, 13'd0}},
        '{'{REQ_FREE,  12'd0,    13'd4096}, 1'b1, '{1'b1, 12'd0,    13'd4096}},
        '{'{REQ_FREE,  12'd0,    13'd4096}, 1'b1, '{1'b1, 12'd0,    13'd4096}},
        '{'{REQ_ALLOC, 12'd4095, 13'd4096}, 1'b1, '{1'b1, 12'd0,    13'd0}},
        '{'{REQ_ALLOC, 12'd0,    13'd1},    1'b1, '{1'b0, 12'd0,    13'd0}},
        '{'{REQ_FREE,  12'd100,  13'd50},   1'b0, '0},
        '{'{REQ_FREE,  12'd200,  13'd10},   1'b0, '0},
        '{'{REQ_ALLOC, 12'd0,    13'd20},   1'b0, '0},
        '{'{REQ_ALLOC, 12'd0,    13'd40},   1'b0, '0},
        '{'{REQ_ALLOC, 12'd0,    13'd10},   1'b0, '0},
        '{'{REQ_FREE,  12'd2730, 13'd1365}, 1'b0, '0},
        '{'{REQ_FREE,  12'd1365, 13'd2730}, 1'b0, '0},
        '{'{REQ_ALLOC, 12'd0,    13'd4096}, 1'b0, '0},
        '{'{REQ_ALLOC, 12'd0,    13'd3000}, 1'b0, '0},
        '{'{REQ_FREE,  12'd0,    13'd4096}, 1'b0, '0}
    };

    // Page total and length of each random phase
    localparam int unsigned SEG_TOTAL [0:N_SEG-1] = '{4096, 37, 0, 1000, 2500, 4096};
    localparam int unsigned SEG_ITEMS [0:N_SEG-1] = '{300, 200, 30, 250, 200, 250};

    logic             i_clk;
    logic             i_rst_n;
    logic             i_cfg_wr_en;
    logic [CNT_W-1:0] i_cfg_wr_data;

    bpa_req_if req_bus ();
    bpa_res_if res_bus ();

    bitmap_page_allocator_top u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_req         (req_bus),
        .o_res         (res_bus),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data)
    );

    // Shadow of the allocator state
    bit               page_used [NUM_PAGES_DEF];
    int unsigned      shadow_free;
    logic [CNT_W-1:0] page_total_reg;

    t_page_res   pending_q [$];
    t_page_run   alloc_runs [$];
    int unsigned bad_cnt;
    int unsigned cyc_cnt;
    int unsigned snd_idle;
    int unsigned rcv_idle;
    bit          res_hold_req;

    // Clock
    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic int unsigned page_limit();
        return (page_total_reg > NUM_PAGES_DEF) ? NUM_PAGES_DEF : 32'(page_total_reg);
    endfunction

    // Apply one request to the shadow state and return its result
    function automatic t_page_res predict_page_op(input t_page_req rq);
        t_page_res   res;
        int unsigned lim;
        int unsigned run;
        int unsigned start;
        int unsigned stop;
        int unsigned i;
        lim            = page_limit();
        res.ok         = 1'b1;
        res.first_page = '0;
        if (rq.req_type == REQ_ALLOC) begin
            res.ok = 1'b0;
            run    = 0;
            start  = 0;
            if (rq.count != 0 && rq.count <= shadow_free && rq.count <= lim) begin
                // First fit: lowest run of free pages below the total
                for (i = 0; i < lim && !res.ok; i++) begin
                    if (page_used[i]) begin
                        run = 0;
                    end else begin
                        if (run == 0) start = i;
                        run++;
                        if (run == rq.count) res.ok = 1'b1;
                    end
                end
                if (res.ok) begin
                    for (i = start; i < start + rq.count; i++) page_used[i] = 1'b1;
                    shadow_free    = shadow_free - rq.count;
                    res.first_page = start[IDX_W-1:0];
                end
            end
        end else begin
            // Skip pages beyond the total and pages already free
            stop = rq.page_index + rq.count;
            for (i = rq.page_index; i < stop; i++) begin
                if (i < lim && page_used[i]) begin
                    page_used[i] = 1'b0;
                    shadow_free++;
                end
            end
        end
        res.free_count = shadow_free[CNT_W-1:0];
        return res;
    endfunction

    // Random request: mostly allocations and frees of earlier runs, some noise
    function automatic t_page_req make_page_req();
        t_page_req   rq;
        int unsigned sel;
        int unsigned k;
        sel           = $urandom_range(99);
        k             = $urandom_range(19);
        rq.req_type   = REQ_ALLOC;
        rq.page_index = IDX_W'($urandom_range(4095));
        rq.count      = '0;
        if (sel < 45) begin
            if (k < 12)       rq.count = CNT_W'($urandom_range(1, 8));
            else if (k < 16)  rq.count = CNT_W'($urandom_range(9, 64));
            else if (k == 16) rq.count = '0;
            else if (k == 17) rq.count = CNT_W'((shadow_free < 4096) ? shadow_free + 1 : 4096);
            else if (k == 18) rq.count = CNT_W'((shadow_free == 0) ? 1 : shadow_free);
            else              rq.count = CNT_W'($urandom_range(0, 4096));
        end else if (sel < 82 && alloc_runs.size() != 0) begin
            k             = $urandom_range(alloc_runs.size() - 1);
            rq.req_type   = REQ_FREE;
            rq.page_index = alloc_runs[k].start[IDX_W-1:0];
            rq.count      = alloc_runs[k].len[CNT_W-1:0];
            alloc_runs.delete(k);
        end else begin
            rq.req_type = REQ_FREE;
            if (k < 12)       rq.count = CNT_W'($urandom_range(0, 32));
            else if (k < 18)  rq.count = CNT_W'($urandom_range(0, 512));
            else if (k == 18) rq.count = 13'd4096;
            else              rq.count = CNT_W'($urandom_range(0, 4096));
        end
        return rq;
    endfunction

    // Offer one beat, optionally after an idle gap, and record its result
    task automatic send_req(input t_page_req rq, input logic has_want, input t_page_res want);
        t_page_res pred;
        if ($urandom_range(99) < snd_idle) begin
            req_bus.valid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(99) < snd_idle);
        end
        req_bus.valid      <= 1'b1;
        req_bus.req_type   <= rq.req_type;
        req_bus.page_index <= rq.page_index;
        req_bus.count      <= rq.count;
        do @(posedge i_clk); while (!req_bus.ready);
        pred = predict_page_op(rq);
        pending_q.push_back(has_want ? want : pred);
        if (rq.req_type == REQ_ALLOC && pred.ok)
            alloc_runs.push_back('{32'(pred.first_page), 32'(rq.count)});
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain_results();
        req_bus.valid <= 1'b0;
        while (pending_q.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_page_total(input logic [CNT_W-1:0] val);
        drain_results();
        repeat (4) @(posedge i_clk);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= val;
        @(posedge i_clk);
        i_cfg_wr_en    <= 1'b0;
        page_total_reg  = val;
    endtask

    // Result side: check each beat against the oldest prediction, drive ready
    initial begin
        t_page_res   want;
        int unsigned hold_left;
        hold_left      = 0;
        res_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && res_bus.valid && res_bus.ready) begin
                if (pending_q.size() == 0) begin
                    bad_cnt++;
                    if (bad_cnt <= 10)
                        $display("unexpected result: ok=%0d first_page=%0d free_count=%0d",
                                 res_bus.ok, res_bus.first_page, res_bus.free_count);
                end else begin
                    want = pending_q.pop_front();
                    if (res_bus.ok !== want.ok || res_bus.first_page !== want.first_page ||
                        res_bus.free_count !== want.free_count) begin
                        bad_cnt++;
                        if (bad_cnt <= 10)
                            $display("mismatch: ok %0d/%0d first_page %0d/%0d free_count %0d/%0d",
                                     want.ok, res_bus.ok, want.first_page, res_bus.first_page,
                                     want.free_count, res_bus.free_count);
                    end
                end
            end
            // Hold off for a long stretch once, otherwise stall at random
            if (res_hold_req && hold_left == 0) begin
                res_hold_req = 1'b0;
                hold_left    = RES_HOLD;
            end
            if (hold_left != 0) begin
                hold_left--;
                res_bus.ready <= 1'b0;
            end else begin
                res_bus.ready <= ($urandom_range(99) >= rcv_idle);
            end
        end
    end

    // Timeout
    initial begin
        cyc_cnt = 0;
        while (cyc_cnt < LIMIT_CYCLES) begin
            @(posedge i_clk);
            cyc_cnt++;
        end
        $display("CHECK FAILED");
        $finish;
    end

    // Request side and phase control
    initial begin
        int unsigned s;
        int unsigned n;
        bad_cnt        = 0;
        res_hold_req   = 1'b0;
        snd_idle       = 9;
        rcv_idle       = 49;
        shadow_free    = 0;
        page_total_reg = RANGE_RESET;
        foreach (page_used[i]) page_used[i] = 1'b1;

        i_rst_n            <= 1'b0;
        i_cfg_wr_en        <= 1'b0;
        i_cfg_wr_data      <= '0;
        req_bus.valid      <= 1'b0;
        req_bus.req_type   <= REQ_ALLOC;
        req_bus.page_index <= '0;
        req_bus.count      <= '0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Walk the directed table at the full page total
        write_page_total(13'd4096);
        for (n = 0; n < N_DIR; n++)
            send_req(DIR_TAB[n].rq, DIR_TAB[n].has_want, DIR_TAB[n].want);

        // Random phases, each with its own page total and idle pattern
        for (s = 0; s < N_SEG; s++) begin
            if (s < 2) begin
                snd_idle = 9;
                rcv_idle = 49;
            end else if (s < 4) begin
                snd_idle = 49;
                rcv_idle = 9;
            end else begin
                snd_idle = 0;
                rcv_idle = 0;
            end
            write_page_total(SEG_TOTAL[s][CNT_W-1:0]);
            for (n = 0; n < SEG_ITEMS[s]; n++) begin
                if (s == 0 && n == 100) res_hold_req = 1'b1;
                if (s == 3 && n == 120) drain_results();
                send_req(make_page_req(), 1'b0, '0);
            end
        end

        // Let the last results arrive, then allow for stray beats
        drain_results();
        repeat (300) @(posedge i_clk);
        if (bad_cnt == 0 && pending_q.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

// File: sim.f
+incdir+src
src/bpa_pkg.sv
src/bpa_req_if.sv
src/bpa_res_if.sv
src/bpa_ram.sv
src/bitmap_page_allocator_top.sv
test/bitmap_page_allocator_top_tb.sv
